/* hw/rtl/freshness_counter_table_unit_assert.svh */
// ----------------------------------------------------------------------------
// Freshness counter table assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef FRESHNESS_COUNTER_TABLE_UNIT_ASSERT_SVH
`define FRESHNESS_COUNTER_TABLE_UNIT_ASSERT_SVH

// Property must hold at every edge outside reset
`define FCTU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Expression must never be true outside reset
`define FCTU_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

/* hw/rtl/fctu_pkg.sv */
// ----------------------------------------------------------------------------
// Freshness counter table package
// Types, constants and helpers shared by the table unit.
// ----------------------------------------------------------------------------
package fctu_pkg;

   // Table geometry
   localparam int NUM_PDUS = 64;
   localparam int ADDR_W   = $clog2(NUM_PDUS);

   // Field widths
   localparam int CMD_W      = 3;
   localparam int ID_W       = 6;
   localparam int VALUE_W    = 64;
   localparam int VLEN_W     = 8;
   localparam int CW_W       = 4;
   localparam int STATUS_W   = 3;
   localparam int RATIO_W    = 9;
   localparam int PROD_W     = VALUE_W + RATIO_W;
   localparam int ENTRY_W    = VALUE_W + CW_W + VALUE_W;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_WARN_RATIO = 1'b0;
   localparam logic [RATIO_W-1:0] WARN_RATIO_RESET = 9'd230;

   // Freshness byte handling
   localparam logic [CW_W-1:0] MAX_BYTES = 4'd8;
   localparam logic [7:0]      BYTE_MASK = 8'hFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_REGISTER   = 3'd0,
      CMD_UNREGISTER = 3'd1,
      CMD_READ       = 3'd2,
      CMD_INCREMENT  = 3'd3,
      CMD_VERIFY     = 3'd4,
      CMD_RESET      = 3'd5,
      CMD_LOAD       = 3'd6
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK             = 3'd0,
      STS_NOT_REGISTERED = 3'd1,
      STS_ALREADY_REG    = 3'd2,
      STS_OVERFLOW       = 3'd3,
      STS_BAD_LENGTH     = 3'd4,
      STS_STALE          = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [ID_W-1:0]    pdu_id;
      logic [VALUE_W-1:0] value;
      logic [VLEN_W-1:0]  value_length;
      logic [CW_W-1:0]    counter_width;
      logic [VALUE_W-1:0] max_counter;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  counter_value;
      logic [VALUE_W-1:0]  freshness_out;
      logic [CW_W-1:0]     freshness_length;
      logic                near_overflow;
   } rsp_type;

   // One table entry as held in the memory
   typedef struct packed {
      logic [VALUE_W-1:0] max_counter;
      logic [CW_W-1:0]    width;
      logic [VALUE_W-1:0] counter;
   } entry_type;

   // Mask keeping the low nbytes bytes of a 64-bit word
   function automatic logic [VALUE_W-1:0] byte_mask(input logic [CW_W-1:0] nbytes);
      logic [VALUE_W-1:0] mask;
      mask = '0;
      for (int i = 0; i < VALUE_W / 8; i++) begin
         if (CW_W'(i) < nbytes) begin
            mask[i*8 +: 8] = BYTE_MASK;
         end
      end
      return mask;
   endfunction

endpackage

/* hw/rtl/fctu_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module fctu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/freshness_counter_table_unit.sv */
// ----------------------------------------------------------------------------
// Freshness counter table unit
// Per-PDU freshness counters held in one table memory, one command per
// transaction, one result per transaction.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_stall  fctu_pkg::req_type
//   rsp_     out        rsp_valid / rsp_stall  fctu_pkg::rsp_type
//   csr_     in/out     APB write/read         warn_ratio_q8 at byte 0
//
// A transaction runs through accept with table read, entry update and
// write-back with the max * ratio product, then the near-overflow compare
// into the output register. No new one is taken while one is in flight.
// The next transaction is taken once the result sits in the output register,
// even while rsp_stall holds it; a held result stalls the compare stage.
// Reset is synchronous: valid marks clear at once, there is no clearing pass.
//
module freshness_counter_table_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  fctu_pkg::req_type                     req_data,
   // Result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output fctu_pkg::rsp_type                     rsp_data,
   // Configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [fctu_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [fctu_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [fctu_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   `include "freshness_counter_table_unit_assert.svh"

   fctu_pkg::state_type state_ff, state_in;

   logic                 accept;
   logic                 ram_re;
   logic                 upd_en;
   logic                 rsp_load;
   logic                 ram_we;

   fctu_pkg::req_type    req_ff;
   logic [fctu_pkg::NUM_PDUS-1:0] valid_ff;
   logic [fctu_pkg::RATIO_W-1:0]  warn_ratio_ff, warn_ratio_in;
   logic                 csr_wr;
   logic                 csr_hit;

   logic [fctu_pkg::ADDR_W-1:0]  upd_addr;
   logic [fctu_pkg::ENTRY_W-1:0] ram_rdata;
   fctu_pkg::entry_type  entry_old, entry_new;
   logic                 in_range;
   logic                 valid_old, valid_new;
   logic                 entry_we;
   fctu_pkg::status_type status_new;
   logic [fctu_pkg::VALUE_W-1:0] rx_value;

   // Evaluation stage registers
   fctu_pkg::status_type ev_status_ff;
   logic                 ev_valid_ff;
   logic [fctu_pkg::VALUE_W-1:0] ev_counter_ff;
   logic [fctu_pkg::CW_W-1:0]    ev_width_ff;
   logic                 ev_max_nz_ff;
   logic [fctu_pkg::PROD_W-1:0]  ev_prod_ff;

   fctu_pkg::rsp_type    rsp_in, rsp_data_ff;
   logic                 rsp_valid_ff;
   logic                 near_in;

   assign accept = req_valid && !req_stall;

   // Sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fctu_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = fctu_pkg::ST_READ;
            end
         end
         fctu_pkg::ST_READ: begin
            state_in = fctu_pkg::ST_EVAL;
         end
         fctu_pkg::ST_EVAL: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = fctu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fctu_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      req_stall = 1'b1;
      ram_re    = 1'b0;
      upd_en    = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         fctu_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            ram_re    = req_valid;
         end
         fctu_pkg::ST_READ: begin
            upd_en = 1'b1;
         end
         fctu_pkg::ST_EVAL: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fctu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the accepted transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[fctu_pkg::CSR_ADDR_W-1:2] == fctu_pkg::CSR_IDX_WARN_RATIO);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;

   always_comb begin
      warn_ratio_in = warn_ratio_ff;
      if (csr_wr) begin
         warn_ratio_in = csr_pwdata[fctu_pkg::RATIO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warn_ratio_ff <= fctu_pkg::WARN_RATIO_RESET;
      end else begin
         warn_ratio_ff <= warn_ratio_in;
      end
   end

   assign csr_prdata = csr_hit ? fctu_pkg::CSR_DATA_W'(warn_ratio_ff) : '0;

   // Entry table: counter, width and maximum
   fctu_ram #(
      .WIDTH (fctu_pkg::ENTRY_W),
      .DEPTH (fctu_pkg::NUM_PDUS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (upd_addr),
      .wr_data (entry_new),
      .rd_en   (ram_re),
      .rd_addr (fctu_pkg::ADDR_W'(req_data.pdu_id)),
      .rd_data (ram_rdata)
   );

   assign upd_addr  = fctu_pkg::ADDR_W'(req_ff.pdu_id);
   assign entry_old = ram_rdata;
   assign in_range  = (32'(req_ff.pdu_id) < 32'(fctu_pkg::NUM_PDUS));
   assign valid_old = in_range && valid_ff[upd_addr];
   assign rx_value  = req_ff.value & fctu_pkg::byte_mask(entry_old.width);

   // Apply the command to the entry read from the table
   always_comb begin
      entry_new  = entry_old;
      valid_new  = valid_old;
      entry_we   = 1'b0;
      status_new = fctu_pkg::STS_OK;
      priority if (!in_range) begin
         status_new = (fctu_pkg::cmd_type'(req_ff.command) == fctu_pkg::CMD_UNREGISTER) ?
                      fctu_pkg::STS_OK : fctu_pkg::STS_NOT_REGISTERED;
      end else if (fctu_pkg::cmd_type'(req_ff.command) == fctu_pkg::CMD_REGISTER) begin
         if (valid_old) begin
            status_new = fctu_pkg::STS_ALREADY_REG;
         end else begin
            valid_new             = 1'b1;
            entry_we              = 1'b1;
            entry_new.counter     = '0;
            entry_new.width       = (req_ff.counter_width > fctu_pkg::MAX_BYTES) ?
                                    fctu_pkg::MAX_BYTES : req_ff.counter_width;
            entry_new.max_counter = req_ff.max_counter;
         end
      end else if (fctu_pkg::cmd_type'(req_ff.command) == fctu_pkg::CMD_UNREGISTER) begin
         valid_new = 1'b0;
      end else if (!valid_old) begin
         status_new = fctu_pkg::STS_NOT_REGISTERED;
      end else begin
         unique case (fctu_pkg::cmd_type'(req_ff.command))
            fctu_pkg::CMD_INCREMENT: begin
               if ((entry_old.max_counter != '0) &&
                   (entry_old.counter >= entry_old.max_counter)) begin
                  status_new = fctu_pkg::STS_OVERFLOW;
               end else begin
                  entry_new.counter = entry_old.counter + fctu_pkg::VALUE_W'(1);
                  entry_we          = 1'b1;
               end
            end
            fctu_pkg::CMD_VERIFY: begin
               if (req_ff.value_length != fctu_pkg::VLEN_W'(entry_old.width)) begin
                  status_new = fctu_pkg::STS_BAD_LENGTH;
               end else if (rx_value <= entry_old.counter) begin
                  status_new = fctu_pkg::STS_STALE;
               end else begin
                  entry_new.counter = rx_value;
                  entry_we          = 1'b1;
               end
            end
            fctu_pkg::CMD_RESET: begin
               entry_new.counter = '0;
               entry_we          = 1'b1;
            end
            fctu_pkg::CMD_LOAD: begin
               entry_new.counter = req_ff.value;
               entry_we          = 1'b1;
            end
            default: begin
               // read and the unused code report the entry unchanged
               entry_we = 1'b0;
            end
         endcase
      end
   end

   assign ram_we = upd_en && entry_we;

   // Valid marks
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (upd_en && in_range) begin
         valid_ff[upd_addr] <= valid_new;
      end
   end

   // Advance into the evaluation stage with the threshold product
   always_ff @(posedge clock) begin
      if (upd_en) begin
         ev_status_ff  <= status_new;
         ev_valid_ff   <= in_range && valid_new;
         ev_counter_ff <= entry_new.counter;
         ev_width_ff   <= entry_new.width;
         ev_max_nz_ff  <= (entry_new.max_counter != '0);
         ev_prod_ff    <= fctu_pkg::PROD_W'(entry_new.max_counter) *
                          fctu_pkg::PROD_W'(warn_ratio_ff);
      end
   end

   // Near-overflow compare and result assembly
   assign near_in = ev_max_nz_ff &&
                    (fctu_pkg::PROD_W'({ev_counter_ff, 8'h00}) >= ev_prod_ff);

   always_comb begin
      rsp_in        = '0;
      rsp_in.status = ev_status_ff;
      if (ev_valid_ff) begin
         rsp_in.counter_value    = ev_counter_ff;
         rsp_in.freshness_out    = ev_counter_ff & fctu_pkg::byte_mask(ev_width_ff);
         rsp_in.freshness_length = ev_width_ff;
         rsp_in.near_overflow    = near_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `FCTU_ASSERT(a_fresh_within_length,
      rsp_valid_ff |-> ((rsp_data_ff.freshness_out &
         ~fctu_pkg::byte_mask(rsp_data_ff.freshness_length)) == '0),
      "freshness has bytes beyond its length")
   `FCTU_ASSERT(a_unregistered_zero,
      (rsp_valid_ff && (rsp_data_ff.status == fctu_pkg::STS_NOT_REGISTERED)) |->
         ((rsp_data_ff.counter_value == '0) && (rsp_data_ff.freshness_length == '0) &&
          !rsp_data_ff.near_overflow),
      "unregistered result carries entry data")
   `FCTU_ASSERT_NEVER(a_no_result_overwrite, rsp_load && rsp_valid_ff && rsp_stall,
      "held result overwritten")
   `FCTU_ASSERT(a_write_marks_valid, ram_we |=> valid_ff[$past(upd_addr)],
      "table written for an entry left invalid")

endmodule
